// ===== rtl/sync_length_frame_parser_heartbeat_unit_assert.svh =====
// Assertion macros for the sync/length frame parser with heartbeat.
// Included by the top level; no other dependencies.
`ifndef SYNC_LENGTH_FRAME_PARSER_HEARTBEAT_UNIT_ASSERT_SVH
`define SYNC_LENGTH_FRAME_PARSER_HEARTBEAT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SLFPH_ASSERT_NOW(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("slfph assertion failed");
`define SLFPH_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("slfph assertion failed");
`else
`define SLFPH_ASSERT_NOW(name, clk, rstn, pre, post)
`define SLFPH_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif

`endif

// ===== rtl/slfph_pkg.sv =====
// Shared types and constants for the sync/length frame parser with heartbeat.
// No dependencies.
`timescale 1ns / 1ps

package slfph_pkg;

    localparam int TICK_COUNT_BITS = 10;
    localparam int CFG_MS_W        = 10;
    localparam int CFG_DATA_W      = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int CMP_W           = (TICK_COUNT_BITS > CFG_MS_W) ? TICK_COUNT_BITS : CFG_MS_W;
    localparam int HDR_LAST_POS    = 5;

    typedef logic [TICK_COUNT_BITS-1:0] tick_cnt_t;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_VALUE      = 3'd0,
        REG_SILENCE_LIMIT   = 3'd1,
        REG_HEARTBEAT_PER   = 3'd2,
        REG_HEARTBEAT_VALUE = 3'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_HUNT    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_DISCARD = 2'd2
    } parser_mode_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] send_value;
        logic [7:0] opcode_high;
        logic       is_heartbeat;
    } out_item_t;

    typedef struct packed {
        logic byte_en;
        logic tick_en;
    } step_t;

    typedef struct packed {
        logic [7:0]          sync_value;
        logic [CFG_MS_W-1:0] silence_limit;
        logic [CFG_MS_W-1:0] heartbeat_period;
        logic [7:0]          hb_value;
    } cfg_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
        logic [7:0] opcode;
    } frame_t;

endpackage

// ===== rtl/slfph_parser.sv =====
// Hunt/collect/discard byte parser; reports a completed header.
// Depends on slfph_pkg.
`timescale 1ns / 1ps

module slfph_parser import slfph_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  step_t      step,
    input  logic [7:0] rx_byte,
    input  logic [7:0] sync_value,
    output frame_t     frame
);

    parser_mode_t mode_reg, mode_next;
    logic [2:0]   pos_reg, pos_next;
    logic [7:0]   len_low_reg, len_low_next;
    logic [7:0]   len_high_reg, len_high_next;
    logic [7:0]   value_reg, value_next;
    logic [15:0]  skip_reg, skip_next;

    logic         hdr_done;
    logic [15:0]  frame_len;
    logic [15:0]  skip_load;
    logic [15:0]  skip_dec;

    assign hdr_done  = (mode_reg == MODE_COLLECT) && (pos_reg >= 3'(HDR_LAST_POS));
    assign frame_len = {len_high_reg, len_low_reg};
    assign skip_load = (frame_len >= 16'd2) ? (frame_len - 16'd2) : 16'd0;
    assign skip_dec  = skip_reg - 16'd1;

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (step.byte_en) begin
            unique case (mode_reg)
                MODE_COLLECT: begin
                    if (hdr_done) begin
                        mode_next = (skip_load != 16'd0) ? MODE_DISCARD : MODE_HUNT;
                    end
                end
                MODE_DISCARD: begin
                    if (skip_dec == 16'd0) begin
                        mode_next = MODE_HUNT;
                    end
                end
                default: begin
                    mode_next = (rx_byte == sync_value) ? MODE_COLLECT : MODE_HUNT;
                end
            endcase
        end
    end

    // header fields, skip count and outputs
    always_comb begin
        pos_next      = pos_reg;
        len_low_next  = len_low_reg;
        len_high_next = len_high_reg;
        value_next    = value_reg;
        skip_next     = skip_reg;
        frame.hit     = 1'b0;
        frame.value   = value_reg;
        frame.opcode  = rx_byte;
        if (step.byte_en) begin
            unique case (mode_reg)
                MODE_COLLECT: begin
                    if (pos_reg == 3'd2) len_low_next  = rx_byte;
                    if (pos_reg == 3'd3) len_high_next = rx_byte;
                    if (pos_reg == 3'd4) value_next    = rx_byte;
                    if (hdr_done) begin
                        pos_next  = 3'd0;
                        skip_next = skip_load;
                        frame.hit = 1'b1;
                    end else begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                MODE_DISCARD: begin
                    skip_next = skip_dec;
                end
                default: begin
                    if (rx_byte == sync_value) begin
                        pos_next = 3'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HUNT;
            pos_reg      <= 3'd0;
            len_low_reg  <= 8'd0;
            len_high_reg <= 8'd0;
            value_reg    <= 8'd0;
            skip_reg     <= 16'd0;
        end else begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            len_low_reg  <= len_low_next;
            len_high_reg <= len_high_next;
            value_reg    <= value_next;
            skip_reg     <= skip_next;
        end
    end

endmodule

// ===== rtl/slfph_beat.sv =====
// Quiet-time tracking and heartbeat request generation.
// Depends on slfph_pkg.
`timescale 1ns / 1ps

module slfph_beat import slfph_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  step_t step,
    input  cfg_t  cfg,
    output logic  beat_hit
);

    localparam tick_cnt_t TICK_MAX = '1;

    logic      active_reg, active_next;
    tick_cnt_t quiet_reg, quiet_next;
    tick_cnt_t since_reg, since_next;

    tick_cnt_t quiet_inc;
    tick_cnt_t since_inc;
    logic      still_active;

    assign quiet_inc    = (quiet_reg == TICK_MAX) ? TICK_MAX : quiet_reg + 1'b1;
    assign since_inc    = (since_reg == TICK_MAX) ? TICK_MAX : since_reg + 1'b1;
    assign still_active = active_reg &&
                          (CMP_W'(quiet_inc) < CMP_W'(cfg.silence_limit));

    always_comb begin
        active_next = active_reg;
        quiet_next  = quiet_reg;
        since_next  = since_reg;
        beat_hit    = 1'b0;
        if (step.byte_en) begin
            active_next = 1'b1;
            quiet_next  = '0;
        end else if (step.tick_en) begin
            quiet_next  = quiet_inc;
            active_next = still_active;
            since_next  = since_inc;
            if (!still_active && (CMP_W'(since_inc) >= CMP_W'(cfg.heartbeat_period))) begin
                since_next = '0;
                beat_hit   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            quiet_reg  <= '0;
            since_reg  <= TICK_MAX;
        end else begin
            active_reg <= active_next;
            quiet_reg  <= quiet_next;
            since_reg  <= since_next;
        end
    end

endmodule

// ===== rtl/sync_length_frame_parser_heartbeat_unit.sv =====
// Top level: input register, parser, heartbeat timer, config registers, result register.
// Depends on slfph_pkg, slfph_parser, slfph_beat and the assertion header.
//
//   channel  ports               direction  payload
//   input    s_valid/s_ready     in         s_item  (action, rx_byte)
//   result   m_valid/m_ready     out        m_item  (send_value, opcode_high, is_heartbeat)
//   config   cfg_we/cfg_index    in         cfg_wdata
//
// One item per cycle sustained while the result register is free; an item that completes a header
// or fires a heartbeat sets m_valid through the input register, state update and result register.
// Reset returns the parser to hunt, the line to inactive and the heartbeat timer to saturated.
// A held result stalls the item in the input register, which in turn drops s_ready.
`timescale 1ns / 1ps
`include "sync_length_frame_parser_heartbeat_unit_assert.svh"

module sync_length_frame_parser_heartbeat_unit import slfph_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    cfg_t      cfg_reg, cfg_next;

    logic      out_free;
    logic      proc;
    step_t     step;
    frame_t    frame;
    logic      beat_hit;

    assign out_free     = !out_valid_reg || m_ready;
    assign proc         = in_valid_reg && out_free;
    assign s_ready      = !in_valid_reg || proc;
    assign step.byte_en = proc && (in_item_reg.action == ACT_BYTE);
    assign step.tick_en = proc && (in_item_reg.action == ACT_TICK);
    assign m_valid      = out_valid_reg;
    assign m_item       = out_item_reg;

    slfph_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .rx_byte    (in_item_reg.rx_byte),
        .sync_value (cfg_reg.sync_value),
        .frame      (frame)
    );

    slfph_beat u_beat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cfg      (cfg_reg),
        .beat_hit (beat_hit)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SYNC_VALUE:      cfg_next.sync_value       = cfg_wdata[7:0];
                REG_SILENCE_LIMIT:   cfg_next.silence_limit    = cfg_wdata[CFG_MS_W-1:0];
                REG_HEARTBEAT_PER:   cfg_next.heartbeat_period = cfg_wdata[CFG_MS_W-1:0];
                REG_HEARTBEAT_VALUE: cfg_next.hb_value         = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (frame.hit) begin
            out_valid_next             = 1'b1;
            out_item_next.send_value   = frame.value;
            out_item_next.opcode_high  = frame.opcode;
            out_item_next.is_heartbeat = 1'b0;
        end else if (beat_hit) begin
            out_valid_next             = 1'b1;
            out_item_next.send_value   = cfg_reg.hb_value;
            out_item_next.opcode_high  = 8'd0;
            out_item_next.is_heartbeat = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.sync_value       <= 8'hAA;
            cfg_reg.silence_limit    <= CFG_MS_W'(100);
            cfg_reg.heartbeat_period <= CFG_MS_W'(10);
            cfg_reg.hb_value         <= 8'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        out_item_reg <= out_item_next;
    end

    `SLFPH_ASSERT_NOW(a_one_source, aclk, aresetn, 1'b1, !(frame.hit && beat_hit))
    `SLFPH_ASSERT_NOW(a_hold_on_stall, aclk, aresetn, out_valid_reg && !m_ready, !proc)
    `SLFPH_ASSERT_NEXT(a_input_loaded, aclk, aresetn, s_valid && s_ready, in_valid_reg)
    `SLFPH_ASSERT_NEXT(a_result_kind, aclk, aresetn, frame.hit || beat_hit,
        out_valid_reg && (out_item_reg.is_heartbeat == $past(beat_hit)))

endmodule
